>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. The enclosing module must provide clk and
// rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition c must hold in the same cycle as a.
`define ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication failed");

// The condition c must hold in the cycle after a.
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

>>> design/cmca_pkg.sv
// ---------------------------------------------------------------------------
// cmca_pkg
// Shared constants and types for the color match centroid angle block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmca_pkg;

  // Frame limits.
  localparam logic [10:0] MAX_WIDTH  = 11'd1024;
  localparam logic [20:0] MAX_PIXELS = 21'd1048576;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_REF_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOV       = 3'd5;

  // Number of quotient bits produced by the divider, one per cycle.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;       // accumulate the pixel on the input ports
    logic mul1;      // count times width, capture count
    logic num;       // numerator and denominator, clear accumulators
    logic mul2;      // numerator magnitude times field of view
    logic div_step;  // one restoring division step
    logic load_out;  // load the result word into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a word that is stalled
  } status_t;

endpackage

`default_nettype wire

>>> design/cmca_ctrl.sv
// ---------------------------------------------------------------------------
// cmca_ctrl
// Sequencer: pixel accumulation, end-of-frame arithmetic and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmca_ctrl
  import cmca_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    last_pixel,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_ACC: begin
        cmd.acc = in_valid;
        if (in_valid && last_pixel) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2     = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_ACC;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  assign in_stall = (state != S_ACC);

endmodule

`default_nettype wire

>>> design/cmca_dp.sv
// ---------------------------------------------------------------------------
// cmca_dp
// Datapath: configuration, color distance, accumulators, divider, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmca_dp
  import cmca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic                 last_pixel,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      found,
  output logic signed [15:0]        angle,
  output logic [20:0]               matched_pixels
);

  // Configuration.
  logic [7:0]  ref_red;
  logic [7:0]  ref_green;
  logic [7:0]  ref_blue;
  logic [9:0]  match_threshold;
  logic [10:0] image_width;
  logic [15:0] field_of_view;

  // Frame accumulators.
  logic [9:0]  column;
  logic [29:0] column_sum;
  logic [20:0] match_count;

  // End-of-frame arithmetic.
  logic [30:0] prod_cw;
  logic [20:0] res_count;
  logic        res_found;
  logic        neg;
  logic [30:0] mag;
  logic [31:0] den;
  logic [30:0] rem;
  logic [15:0] quo;

  logic [10:0] eff_w;
  logic [7:0]  d_red;
  logic [7:0]  d_green;
  logic [7:0]  d_blue;
  logic [9:0]  color_dist;
  logic [9:0]  col0;
  logic [10:0] col_inc;
  logic [9:0]  col_after;
  logic        hit;
  logic [31:0] num;
  logic [46:0] product;
  logic [31:0] trial;
  logic        trial_ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_red         <= 8'd132;
      ref_green       <= 8'd119;
      ref_blue        <= 8'd48;
      match_threshold <= 10'd30;
      image_width     <= 11'd64;
      field_of_view   <= 16'd13107;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_RED:   ref_red         <= cfg_data[7:0];
        REG_REF_GREEN: ref_green       <= cfg_data[7:0];
        REG_REF_BLUE:  ref_blue        <= cfg_data[7:0];
        REG_THRESHOLD: match_threshold <= cfg_data[9:0];
        REG_WIDTH:     image_width     <= cfg_data[10:0];
        REG_FOV:       field_of_view   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A width of zero counts as one, and widths above the maximum are clipped.
  always_comb begin
    if (image_width == 11'd0) begin
      eff_w = 11'd1;
    end else if (image_width > MAX_WIDTH) begin
      eff_w = MAX_WIDTH;
    end else begin
      eff_w = image_width;
    end
  end

  assign d_red      = (red > ref_red) ? red - ref_red : ref_red - red;
  assign d_green    = (green > ref_green) ? green - ref_green : ref_green - green;
  assign d_blue     = (blue > ref_blue) ? blue - ref_blue : ref_blue - blue;
  assign color_dist = {2'b00, d_red} + {2'b00, d_green} + {2'b00, d_blue};

  // The column restarts if the width was lowered under it.
  assign col0      = ({1'b0, column} >= eff_w) ? 10'd0 : column;
  assign col_inc   = {1'b0, col0} + 11'd1;
  assign col_after = (last_pixel || col_inc >= eff_w) ? 10'd0 : col_inc[9:0];
  assign hit       = (color_dist < match_threshold) && (match_count < MAX_PIXELS);

  assign num     = {1'b0, column_sum, 1'b0} - {1'b0, prod_cw};
  assign product = mag * field_of_view;
  assign trial   = {rem, quo[15]};
  assign trial_ge = (trial >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      column_sum  <= '0;
      match_count <= '0;
    end else if (cmd.acc) begin
      column <= col_after;
      if (hit) begin
        column_sum  <= column_sum + {20'd0, col0};
        match_count <= match_count + 21'd1;
      end
    end else if (cmd.num) begin
      column      <= '0;
      column_sum  <= '0;
      match_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_cw   <= {10'd0, match_count} * {20'd0, eff_w};
      res_count <= match_count;
      res_found <= (match_count != 21'd0);
    end
    if (cmd.num) begin
      neg <= num[31];
      mag <= num[31] ? 31'(-num) : num[30:0];
      den <= {prod_cw, 1'b0};
    end
    if (cmd.mul2) begin
      rem <= product[46:16];
      quo <= product[15:0];
    end else if (cmd.div_step) begin
      rem <= trial_ge ? 31'(trial - den) : trial[30:0];
      quo <= {quo[14:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found          <= res_found;
      matched_pixels <= res_count;
      if (!res_found) begin
        angle <= 16'sd0;
      end else if (neg) begin
        angle <= -$signed(quo);
      end else begin
        angle <= $signed(quo);
      end
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

>>> design/color_match_centroid_angle.sv
// ---------------------------------------------------------------------------
// color_match_centroid_angle
// Color-threshold centroid of a camera frame, reported as a Q2.14 angle.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake            word
//   pixel     in         in_valid / in_stall  red, green, blue, last_pixel
//   result    out        out_valid/out_stall  found, angle, matched_pixels
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Pixels are taken one per cycle while a frame is in progress. After the word
// that carries last_pixel, the input stalls while the block multiplies count
// times width, forms the numerator, multiplies by the field of view and runs
// the 16-bit restoring divider, one quotient bit per cycle, then loads the
// result. If the previous result is still stalled at the output, the input
// stays stalled until it is taken. Reset is synchronous and needs no clearing
// pass; configuration is accepted on every cycle.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module color_match_centroid_angle
  import cmca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic                 last_pixel,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      found,
  output logic signed [15:0]        angle,
  output logic [20:0]               matched_pixels,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Registers may be written at any time; the user writes them between frames.
  assign cfg_ready = 1'b1;

  // The controller sequences the end-of-frame arithmetic and owns the input
  // stall; the datapath holds every register of the computation.
  cmca_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_pixel (last_pixel),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  cmca_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_pixel     (last_pixel),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .found          (found),
    .angle          (angle),
    .matched_pixels (matched_pixels)
  );

  // A result is never loaded over a stalled word.
  `ASSERT_IMPL(a_no_overwrite, cmd.load_out, !status.out_busy)
  // The last pixel of a frame starts the end-of-frame computation.
  `ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_pixel, in_stall)
  // An empty frame reports a zero angle and a zero count.
  `ASSERT_IMPL(a_empty_frame, out_valid && !found,
               angle == 16'sd0 && matched_pixels == 21'd0)

endmodule

`default_nettype wire
